@@ design/grdc_pkg.sv @@
// ----------------------------------------------------------------------------
// grdc_pkg
// Shared types and constants for the grid ray caster.
// ----------------------------------------------------------------------------
package grdc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int DIST_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_W   = 3'd6;

    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_LEFT  = 2'd2;
    localparam logic [1:0] ST_BADC  = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // classified command passed from front to back
    typedef struct packed {
        logic        is_cast;
        logic [10:0] column;
        logic [4:0]  cell_row;
        logic [4:0]  cell_col;
        logic [3:0]  cell_value;
    } t_cmd;

endpackage

@@ design/grid_ray_dda_caster_top.sv @@
// Cast flow: camera divide, ray, square, root, row and column delta divides, side init,
// then DDA steps through step, read and check states until a hit, leaving the map or the
// step limit; a bad column goes straight to the result word.
// Concurrency: one cast at a time in the ray engine; the next word is taken the cycle after
// the result word is accepted; map writes land at the pop; a 2-word queue buffers input.
// Reset: synchronous active low; map cleared by a sweep of every map cell.
// ----------------------------------------------------------------------------
// grid_ray_dda_caster_top
// Grid ray caster with config registers, command queue and ray engine.
// ----------------------------------------------------------------------------
module grid_ray_dda_caster_top #(
    parameter int MAP_SIZE  = 32,
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [10:0] i_column,
    input  logic [4:0]  i_cell_row,
    input  logic [4:0]  i_cell_col,
    input  logic [3:0]  i_cell_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_hit_row,
    output logic [4:0]  o_hit_col,
    output logic        o_hit_side,
    output logic [3:0]  o_wall_code,
    output logic [23:0] o_side_dist_row,
    output logic [23:0] o_side_dist_col,
    output logic [1:0]  o_status
);
    import grdc_pkg::*;

    logic [20:0] r_pos_x, r_pos_y;
    logic [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [11:0] r_scr_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 21'd65536;
            r_pos_y   <= 21'd65536;
            r_dir_x   <= 16'hC000;
            r_dir_y   <= 16'd0;
            r_plane_x <= 16'd0;
            r_plane_y <= 16'd10813;
            r_scr_w   <= 12'd640;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data[15:0];
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data[15:0];
                CFG_PLANE_X: r_plane_x <= i_cfg_data[15:0];
                CFG_PLANE_Y: r_plane_y <= i_cfg_data[15:0];
                CFG_SCR_W:   r_scr_w   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    grdc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_column(i_column), .i_cell_row(i_cell_row),
        .i_cell_col(i_cell_col), .i_cell_value(i_cell_value),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    grdc_back #(.MAP_SIZE(MAP_SIZE), .MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .i_pos_x(r_pos_x), .i_pos_y(r_pos_y), .i_dir_x(r_dir_x), .i_dir_y(r_dir_y),
        .i_plane_x(r_plane_x), .i_plane_y(r_plane_y), .i_scr_w(r_scr_w),
        .o_valid(o_valid), .i_ready(i_ready), .o_hit_row(o_hit_row),
        .o_hit_col(o_hit_col), .o_hit_side(o_hit_side), .o_wall_code(o_wall_code),
        .o_side_dist_row(o_side_dist_row), .o_side_dist_col(o_side_dist_col),
        .o_status(o_status)
    );
endmodule

@@ design/grdc_ram.sv @@
// ----------------------------------------------------------------------------
// grdc_ram
// Generic single-port-write, one-read RAM with registered read.
// ----------------------------------------------------------------------------
module grdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/grdc_front.sv @@
// ----------------------------------------------------------------------------
// grdc_front
// Input stage and two-entry command queue feeding the ray engine.
// ----------------------------------------------------------------------------
module grdc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_func,
    input  logic [10:0]    i_column,
    input  logic [4:0]     i_cell_row,
    input  logic [4:0]     i_cell_col,
    input  logic [3:0]     i_cell_value,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output grdc_pkg::t_cmd o_cmd
);
    import grdc_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_cmd       cmd_in;

    assign cmd_in.is_cast    = (i_func == FUNC_CAST);
    assign cmd_in.column     = i_column;
    assign cmd_in.cell_row   = i_cell_row;
    assign cmd_in.cell_col   = i_cell_col;
    assign cmd_in.cell_value = i_cell_value;

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && push) |=> o_cmd_valid)
        else $error("pushed word lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2))
        else $error("full count changed without pop");
endmodule

@@ design/grdc_back.sv @@
// ----------------------------------------------------------------------------
// grdc_back
// Ray engine and wall map: camera setup with iterative divide and root, then DDA walk.
// ----------------------------------------------------------------------------
module grdc_back #(
    parameter int MAP_SIZE  = 32,
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  grdc_pkg::t_cmd i_cmd,
    input  logic [20:0]    i_pos_x,
    input  logic [20:0]    i_pos_y,
    input  logic [15:0]    i_dir_x,
    input  logic [15:0]    i_dir_y,
    input  logic [15:0]    i_plane_x,
    input  logic [15:0]    i_plane_y,
    input  logic [11:0]    i_scr_w,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [4:0]     o_hit_row,
    output logic [4:0]     o_hit_col,
    output logic           o_hit_side,
    output logic [3:0]     o_wall_code,
    output logic [23:0]    o_side_dist_row,
    output logic [23:0]    o_side_dist_col,
    output logic [1:0]     o_status
);
    import grdc_pkg::*;

    localparam int MB  = $clog2(MAP_SIZE);
    localparam int AW  = 2 * MB;
    localparam int DEP = MAP_SIZE * MAP_SIZE;
    localparam int CW  = MB + 2;
    localparam int SCW = $clog2(MAX_STEPS + 1);
    localparam int NUM_W = 46 + FRAC_BITS;
    localparam int DEN_W = 32;
    localparam int QW  = 25;
    localparam int PW  = 21 - FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_CAM, S_RAY, S_SQ, S_ROOT, S_DIVR, S_DIVC,
        S_SIDE, S_STEP, S_READ, S_CHECK, S_OUT
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [AW-1:0] r_clr;

    // camera divide: |2c-w|*2^14 / w, 26-bit numerator
    logic [25:0] r_dnum;
    logic [11:0] r_dden;
    logic [25:0] r_drem;
    logic [14:0] r_dq;
    logic        r_dneg;
    logic [4:0]  r_dcnt;
    logic signed [15:0] r_cam;
    logic signed [17:0] r_rx, r_ry;
    logic [35:0] r_mag2;
    // root: 64-bit radicand, bit pair per cycle
    logic [63:0] r_rad;
    logic [33:0] r_root;
    logic [35:0] r_rrem;
    logic [4:0]  r_rcnt;
    // delta divide: bit serial quotient, saturating
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   r_qrem;
    logic [QW-1:0]    r_q;
    logic [6:0]       r_qcnt;
    logic [DIST_W-1:0] r_dr, r_dc;
    logic [DIST_W-1:0] r_sr, r_sc;
    logic [CW-1:0] r_row, r_col;
    logic r_side;
    logic [SCW-1:0] r_steps;
    logic [3:0] r_code;
    logic [1:0] r_status;
    logic r_ovalid;
    logic [1:0] r_mulsel;
    logic signed [33:0] r_prod;

    // ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [3:0]    ram_wdata, ram_rdata;

    grdc_ram #(.WIDTH(4), .DEPTH(DEP)) u_map (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    logic wr_ok;
    assign wr_ok = ({3'b0, i_cmd.cell_row} < 8'(MAP_SIZE))
                && ({3'b0, i_cmd.cell_col} < 8'(MAP_SIZE));
    assign ram_we    = (r_state == S_CLEAR)
                    || (o_cmd_ready && i_cmd_valid && !i_cmd.is_cast && wr_ok);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr :
                       AW'({i_cmd.cell_row[MB-1:0], i_cmd.cell_col[MB-1:0]});
    assign ram_wdata = (r_state == S_CLEAR) ? 4'd0 : i_cmd.cell_value;
    assign ram_raddr = {r_row[MB-1:0], r_col[MB-1:0]};

    assign o_cmd_ready = (r_state == S_IDLE) && !r_ovalid;

    // combinational step helpers
    logic [25:0] dtrial;
    logic [26:0] dsub;
    assign dtrial = {r_drem[24:0], r_dnum[25]};
    assign dsub   = {1'b0, dtrial} - {15'd0, r_dden};

    logic [35:0] rtrial;
    logic [36:0] rsub;
    assign rtrial = {r_rrem[33:0], r_rad[63:62]};
    assign rsub   = {1'b0, rtrial} - {1'b0, r_root, 2'b01};

    logic [DEN_W:0] qtrial;
    logic [DEN_W+1:0] qsub;
    assign qtrial = {r_qrem[DEN_W-1:0], r_num[NUM_W-1]};
    assign qsub   = {1'b0, qtrial} - {2'b0, r_den};

    logic [DIST_W:0] sr_add, sc_add;
    assign sr_add = {1'b0, r_sr} + {1'b0, r_dr};
    assign sc_add = {1'b0, r_sc} + {1'b0, r_dc};

    logic [FRAC_BITS:0] f_r, f_c;
    assign f_r = r_rx[17] ? {1'b0, i_pos_x[FRAC_BITS-1:0]}
                          : ONE - {1'b0, i_pos_x[FRAC_BITS-1:0]};
    assign f_c = r_ry[17] ? {1'b0, i_pos_y[FRAC_BITS-1:0]}
                          : ONE - {1'b0, i_pos_y[FRAC_BITS-1:0]};
    logic [FRAC_BITS+DIST_W:0] fr_prod, fc_prod;
    assign fr_prod = f_r * r_dr;
    assign fc_prod = f_c * r_dc;
    logic [FRAC_BITS+DIST_W:0] fr_sh, fc_sh;
    assign fr_sh = fr_prod >> FRAC_BITS;
    assign fc_sh = fc_prod >> FRAC_BITS;

    logic [PW-1:0] ipx, ipy;
    assign ipx = i_pos_x[20:FRAC_BITS];
    assign ipy = i_pos_y[20:FRAC_BITS];

    function automatic logic in_map(input logic [CW-1:0] r, input logic [CW-1:0] c);
        in_map = (r < CW'(MAP_SIZE)) && (c < CW'(MAP_SIZE));
    endfunction

    logic [17:0] abs_rx, abs_ry;
    assign abs_rx = r_rx[17] ? 18'(-r_rx) : 18'(r_rx);
    assign abs_ry = r_ry[17] ? 18'(-r_ry) : 18'(r_ry);

    logic signed [12:0] diff;
    assign diff = $signed({1'b0, r_cmd.column, 1'b0}) - $signed({1'b0, i_scr_w});

    logic signed [33:0] prod_abs_q;
    assign prod_abs_q = r_prod[33] ? -((-r_prod) >>> 14) : (r_prod >>> 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEP - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid && !r_ovalid && i_cmd.is_cast) begin
                        r_cmd <= i_cmd;
                        if (i_scr_w == 12'd0 || {1'b0, i_cmd.column} >= i_scr_w) begin
                            r_status <= ST_BADC;
                            r_row <= '0; r_col <= '0; r_side <= 1'b0;
                            r_code <= 4'd0; r_sr <= '0; r_sc <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CAM;
                            r_dcnt  <= '0;
                            r_drem  <= '0;
                            r_dden  <= i_scr_w;
                            r_dq    <= '0;
                        end
                    end
                end
                S_CAM: begin
                    if (r_dcnt == 5'd0) begin
                        r_dneg <= diff[12];
                        r_dnum <= {(diff[12] ? 12'(-diff) : 12'(diff)), 14'd0};
                        r_dcnt <= 5'd1;
                    end else begin
                        r_dnum <= {r_dnum[24:0], 1'b0};
                        if (!dsub[26]) begin
                            r_drem <= dsub[25:0];
                            r_dq   <= {r_dq[13:0], 1'b1};
                        end else begin
                            r_drem <= dtrial;
                            r_dq   <= {r_dq[13:0], 1'b0};
                        end
                        if (r_dcnt == 5'd26) begin
                            r_state  <= S_RAY;
                            r_mulsel <= 2'd0;
                        end
                        r_dcnt <= r_dcnt + 5'd1;
                    end
                end
                S_RAY: begin
                    if (r_mulsel == 2'd0) begin
                        r_cam <= r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                        r_mulsel <= 2'd3;
                    end else if (r_mulsel == 2'd3) begin
                        r_prod <= 34'($signed(i_plane_x) * r_cam);
                        r_mulsel <= 2'd1;
                    end else if (r_mulsel == 2'd1) begin
                        r_rx <= 18'($signed(i_dir_x) + prod_abs_q);
                        r_prod <= 34'($signed(i_plane_y) * r_cam);
                        r_mulsel <= 2'd2;
                    end else begin
                        r_ry <= 18'($signed(i_dir_y) + prod_abs_q);
                        r_state <= S_SQ;
                        r_mulsel <= 2'd0;
                    end
                end
                S_SQ: begin
                    if (r_mulsel == 2'd0) begin
                        r_mag2 <= 36'(abs_rx * abs_rx);
                        r_mulsel <= 2'd1;
                    end else begin
                        r_rad <= {r_mag2 + 36'(abs_ry * abs_ry), 28'd0};
                        r_root <= '0; r_rrem <= '0; r_rcnt <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_rad <= {r_rad[61:0], 2'b00};
                    if (!rsub[36]) begin
                        r_rrem <= rsub[35:0];
                        r_root <= {r_root[32:0], 1'b1};
                    end else begin
                        r_rrem <= rtrial;
                        r_root <= {r_root[32:0], 1'b0};
                    end
                    if (r_rcnt == 5'd31) begin
                        r_state <= S_DIVR;
                        r_num  <= NUM_W'({r_root[32:0], ~rsub[36]}) << FRAC_BITS;
                        r_den  <= DEN_W'(abs_rx) << 14;
                        r_qrem <= '0; r_q <= '0; r_qcnt <= '0;
                    end
                    r_rcnt <= r_rcnt + 5'd1;
                end
                S_DIVR, S_DIVC: begin
                    if (r_qcnt == 7'(NUM_W - 1)) begin
                        if (r_state == S_DIVR) begin
                            r_dr <= (abs_rx == 18'd0 || r_q[QW-1] || r_q[QW-2]) ? DIST_MAX
                                    : DIST_W'({r_q[QW-3:0], ~qsub[DEN_W+1]});
                            r_num  <= NUM_W'(r_root) << FRAC_BITS;
                            r_den  <= DEN_W'(abs_ry) << 14;
                            r_qrem <= '0; r_q <= '0; r_qcnt <= '0;
                            r_state <= S_DIVC;
                        end else begin
                            r_dc <= (abs_ry == 18'd0 || r_q[QW-1] || r_q[QW-2]) ? DIST_MAX
                                    : DIST_W'({r_q[QW-3:0], ~qsub[DEN_W+1]});
                            r_state <= S_SIDE;
                        end
                    end else begin
                        r_num <= {r_num[NUM_W-2:0], 1'b0};
                        if (!qsub[DEN_W+1]) begin
                            r_qrem <= qsub[DEN_W:0];
                            r_q <= r_q[QW-1] ? r_q : {r_q[QW-2:0], 1'b1};
                        end else begin
                            r_qrem <= qtrial;
                            r_q <= r_q[QW-1] ? r_q : {r_q[QW-2:0], 1'b0};
                        end
                        r_qcnt <= r_qcnt + 7'd1;
                    end
                end
                S_SIDE: begin
                    r_sr <= (fr_sh > (FRAC_BITS+DIST_W+1)'(DIST_MAX)) ? DIST_MAX
                            : DIST_W'(fr_sh);
                    r_sc <= (fc_sh > (FRAC_BITS+DIST_W+1)'(DIST_MAX)) ? DIST_MAX
                            : DIST_W'(fc_sh);
                    r_row <= CW'(ipx);
                    r_col <= CW'(ipy);
                    r_side <= 1'b0;
                    r_code <= 4'd0;
                    r_steps <= '0;
                    if ((PW'(ipx) >= PW'(MAP_SIZE) && PW > MB)
                     || (PW'(ipy) >= PW'(MAP_SIZE) && PW > MB)) begin
                        r_status <= ST_LEFT;
                        r_state <= S_OUT;
                    end else begin
                        r_status <= ST_LIMIT;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_steps == SCW'(MAX_STEPS)) begin
                        r_status <= ST_LIMIT;
                        r_state <= S_OUT;
                    end else begin
                        r_steps <= r_steps + 1'b1;
                        if (r_sr < r_sc) begin
                            r_sr <= sr_add[DIST_W] ? DIST_MAX : sr_add[DIST_W-1:0];
                            r_row <= r_rx[17] ? r_row - 1'b1 : r_row + 1'b1;
                            r_side <= 1'b0;
                        end else begin
                            r_sc <= sc_add[DIST_W] ? DIST_MAX : sc_add[DIST_W-1:0];
                            r_col <= r_ry[17] ? r_col - 1'b1 : r_col + 1'b1;
                            r_side <= 1'b1;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (!in_map(r_row, r_col)) begin
                        r_status <= ST_LEFT;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (ram_rdata != 4'd0) begin
                        r_code <= ram_rdata;
                        r_status <= ST_HIT;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_hit_row       = 5'(r_row);
    assign o_hit_col       = 5'(r_col);
    assign o_hit_side      = r_side;
    assign o_wall_code     = r_code;
    assign o_side_dist_row = r_sr;
    assign o_side_dist_col = r_sc;
    assign o_status        = r_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_status)))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_status == ST_HIT) |-> (r_code != 4'd0))
        else $error("hit with empty code");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_steps <= SCW'(MAX_STEPS)))
        else $error("step count overrun");
endmodule

@@ sim/ray_cast_checker.sv @@
// ----------------------------------------------------------------------------
// ray_cast_checker
// Watches the config port and both word channels of the grid ray caster,
// keeps its own copy of the wall map and camera registers, predicts each
// cast result in order and compares it field by field with the output word.
// ----------------------------------------------------------------------------
module ray_cast_checker
    import grdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic        i_func,
    input  logic [10:0] i_column,
    input  logic [4:0]  i_cell_row,
    input  logic [4:0]  i_cell_col,
    input  logic [3:0]  i_cell_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [4:0]  i_hit_row,
    input  logic [4:0]  i_hit_col,
    input  logic        i_hit_side,
    input  logic [3:0]  i_wall_code,
    input  logic [23:0] i_side_dist_row,
    input  logic [23:0] i_side_dist_col,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      GRID   = 32;
    localparam int      STEPS  = 64;
    localparam int      FRAC   = 16;
    localparam longint  ONE    = 64'd1 << FRAC;
    localparam longint  SAT    = 64'hFF_FFFF;

    typedef struct packed {
        logic [4:0]  row;
        logic [4:0]  col;
        logic        side;
        logic [3:0]  code;
        logic [23:0] dist_row;
        logic [23:0] dist_col;
        logic [1:0]  status;
    } ray_hit_t;

    logic [3:0]         wall_map [GRID*GRID];
    logic [20:0]        pos_row, pos_col;
    logic signed [15:0] dir_row, dir_col, plane_row, plane_col;
    logic [11:0]        scr_width;
    ray_hit_t           expected_hits[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint axis_delta(longint len, longint comp);
        longint mag, q;
        mag = comp < 0 ? -comp : comp;
        if (mag == 0) return SAT;
        q = (len << FRAC) / (mag << 14);
        return q > SAT ? SAT : q;
    endfunction

    function automatic longint first_side(longint pos, longint comp, longint delta);
        longint fr, f, s;
        fr = pos & (ONE - 1);
        f = comp < 0 ? fr : ONE - fr;
        s = (f * delta) >> FRAC;
        return s > SAT ? SAT : s;
    endfunction

    function automatic ray_hit_t cast_ray(logic [10:0] column);
        ray_hit_t h;
        longint w, cam, rx, ry, dr, dc, sr, sc, r, c, sr_step, sc_step;
        longint dxr, dxc, pxr, pxc;
        longint unsigned len, sq;
        logic [3:0] code;
        logic [1:0] st;
        logic side;
        h = '0;
        if (scr_width == 0 || column >= scr_width) begin
            h.status = ST_BADC;
            return h;
        end
        w = scr_width;
        cam = ((2 * longint'(column) - w) * 16384) / w;
        dxr = dir_row;
        dxc = dir_col;
        pxr = plane_row;
        pxc = plane_col;
        rx = dxr + (pxr * cam) / 16384;
        ry = dxc + (pxc * cam) / 16384;
        sq = rx * rx + ry * ry;
        len = int_sqrt(sq << 28);
        dr = axis_delta(len, rx);
        dc = axis_delta(len, ry);
        sr = first_side(pos_row, rx, dr);
        sc = first_side(pos_col, ry, dc);
        sr_step = rx < 0 ? -1 : 1;
        sc_step = ry < 0 ? -1 : 1;
        r = pos_row >> FRAC;
        c = pos_col >> FRAC;
        side = 0;
        code = 0;
        st = ST_LIMIT;
        if (r >= GRID || c >= GRID) begin
            st = ST_LEFT;
        end else begin
            for (int n = 0; n < STEPS; n++) begin
                if (sr < sc) begin
                    sr = sr + dr > SAT ? SAT : sr + dr;
                    r = r + sr_step;
                    side = 0;
                end else begin
                    sc = sc + dc > SAT ? SAT : sc + dc;
                    c = c + sc_step;
                    side = 1;
                end
                if (r < 0 || r >= GRID || c < 0 || c >= GRID) begin
                    st = ST_LEFT;
                    break;
                end
                code = wall_map[r*GRID + c];
                if (code != 0) begin
                    st = ST_HIT;
                    break;
                end
            end
        end
        h.row = r[4:0];
        h.col = c[4:0];
        h.side = side;
        h.code = st == ST_HIT ? code : 4'd0;
        h.dist_row = sr[23:0];
        h.dist_col = sc[23:0];
        h.status = st;
        return h;
    endfunction

    always @(posedge i_clk) begin
        ray_hit_t want, got;
        if (!i_rst_n) begin
            foreach (wall_map[k]) wall_map[k] = '0;
            pos_row = 21'd65536;
            pos_col = 21'd65536;
            dir_row = -16'sd16384;
            dir_col = '0;
            plane_row = '0;
            plane_col = 16'sd10813;
            scr_width = 12'd640;
            expected_hits.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POS_X:   pos_row = i_cfg_data;
                    CFG_POS_Y:   pos_col = i_cfg_data;
                    CFG_DIR_X:   dir_row = i_cfg_data[15:0];
                    CFG_DIR_Y:   dir_col = i_cfg_data[15:0];
                    CFG_PLANE_X: plane_row = i_cfg_data[15:0];
                    CFG_PLANE_Y: plane_col = i_cfg_data[15:0];
                    CFG_SCR_W:   scr_width = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_hit_row, i_hit_col, i_hit_side, i_wall_code,
                        i_side_dist_row, i_side_dist_col, i_status};
                o_checked++;
                if (expected_hits.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result word %p", got);
                end else begin
                    want = expected_hits.pop_front();
                    if (want.row !== got.row || want.col !== got.col ||
                        want.side !== got.side || want.code !== got.code ||
                        want.dist_row !== got.dist_row ||
                        want.dist_col !== got.dist_col ||
                        want.status !== got.status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: result mismatch\n  exp %p\n  got %p", want, got);
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                if (i_func == FUNC_WRITE) begin
                    if (i_cell_row < GRID && i_cell_col < GRID)
                        wall_map[i_cell_row*GRID + i_cell_col] = i_cell_value;
                end else begin
                    expected_hits.push_back(cast_ray(i_column));
                end
            end
        end
        o_pending = expected_hits.size();
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the grid ray caster: directed map writes and casts, then fixed and
// random camera setups with random walls and columns, mostly under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import grdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = '0;
    logic [20:0] cfg_data = '0;
    logic        cmd_valid = 0;
    logic        cmd_ready;
    logic        func = 0;
    logic [10:0] column = '0;
    logic [4:0]  cell_row = '0;
    logic [4:0]  cell_col = '0;
    logic [3:0]  cell_value = '0;
    logic        res_valid;
    logic        res_ready = 0;
    logic [4:0]  hit_row, hit_col;
    logic        hit_side;
    logic [3:0]  wall_code;
    logic [23:0] dist_row, dist_col;
    logic [1:0]  status;
    int          fail_count, pending, checked;
    int          n_casts = 0;
    int          n_writes = 0;
    bit          calm = 0;
    bit          started = 0;

    always #4 clk = ~clk;

    grid_ray_dda_caster_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(cmd_valid), .o_ready(cmd_ready),
        .i_func(func), .i_column(column), .i_cell_row(cell_row),
        .i_cell_col(cell_col), .i_cell_value(cell_value),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_hit_row(hit_row), .o_hit_col(hit_col), .o_hit_side(hit_side),
        .o_wall_code(wall_code), .o_side_dist_row(dist_row),
        .o_side_dist_col(dist_col), .o_status(status)
    );

    ray_cast_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(cmd_valid), .i_ready_in(cmd_ready),
        .i_func(func), .i_column(column), .i_cell_row(cell_row),
        .i_cell_col(cell_col), .i_cell_value(cell_value),
        .i_out_valid(res_valid), .i_out_ready(res_ready),
        .i_hit_row(hit_row), .i_hit_col(hit_col), .i_hit_side(hit_side),
        .i_wall_code(wall_code), .i_side_dist_row(dist_row),
        .i_side_dist_col(dist_col), .i_status(status),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // receiver: random stalls, one long hold-off
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (started && cyc > 30000 && cyc <= 32500)
                res_ready <= 0;
            else
                res_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
        end
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 36) begin
            @(negedge clk);
            cmd_valid <= 0;
        end
    endtask

    task automatic send_word(logic f, logic [10:0] c, logic [4:0] r,
                             logic [4:0] cc, logic [3:0] v);
        idle_gap();
        @(negedge clk);
        cmd_valid <= 1;
        func <= f;
        column <= c;
        cell_row <= r;
        cell_col <= cc;
        cell_value <= v;
        do @(posedge clk); while (!cmd_ready);
        if (f == FUNC_CAST) n_casts++;
        else n_writes++;
    endtask

    task automatic cast(logic [10:0] c);
        send_word(FUNC_CAST, c, 5'($urandom), 5'($urandom), 4'($urandom));
    endtask

    task automatic put_cell(logic [4:0] r, logic [4:0] c, logic [3:0] v);
        send_word(FUNC_WRITE, 11'($urandom), r, c, v);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [20:0] data);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(3))
            0: return 16'($urandom_range(0, 600) - 300);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [11:0] width;
        int          n_phase;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        started = 1;

        // directed: default camera looks toward row 0
        cast(11'd0);
        cast(11'd639);
        cast(11'd320);
        cast(11'd640);
        cast(11'd2047);
        put_cell(5'd0, 5'd0, 4'd15);
        put_cell(5'd31, 5'd31, 4'd1);
        put_cell(5'd0, 5'd31, 4'd8);
        put_cell(5'd31, 5'd0, 4'd7);
        put_cell(5'd1, 5'd1, 4'd9);
        cast(11'd320);
        put_cell(5'd0, 5'd1, 4'd15);
        cast(11'd320);
        cast(11'd100);
        put_cell(5'd0, 5'd1, 4'd0);
        cast(11'd320);
        drain();
        set_reg(CFG_SCR_W, 21'd0);
        set_reg(CFG_UNUSED, 21'h1FFFFF);
        cast(11'd0);
        drain();
        set_reg(CFG_SCR_W, 21'd1);
        cast(11'd0);
        cast(11'd1);
        drain();

        for (n_phase = 0; n_phase < 10; n_phase++) begin
            drain();
            case (n_phase)
                0: begin
                    set_reg(CFG_POS_X, 21'd0);
                    set_reg(CFG_POS_Y, 21'd0);
                    set_reg(CFG_DIR_X, 21'h08000);
                    set_reg(CFG_DIR_Y, 21'h07FFF);
                    set_reg(CFG_PLANE_X, 21'h07FFF);
                    set_reg(CFG_PLANE_Y, 21'h08000);
                    width = 12'd2048;
                end
                1: begin
                    set_reg(CFG_POS_X, 21'h1FFFFF);
                    set_reg(CFG_POS_Y, 21'h1FFFFF);
                    set_reg(CFG_DIR_X, 21'h07FFF);
                    set_reg(CFG_DIR_Y, 21'h08000);
                    set_reg(CFG_PLANE_X, 21'h08000);
                    set_reg(CFG_PLANE_Y, 21'h07FFF);
                    width = 12'd2;
                end
                default: begin
                    set_reg(CFG_POS_X, 21'($urandom));
                    set_reg(CFG_POS_Y, 21'($urandom));
                    set_reg(CFG_DIR_X, 21'(rand_comp()));
                    set_reg(CFG_DIR_Y, 21'(rand_comp()));
                    set_reg(CFG_PLANE_X, 21'(rand_comp()));
                    set_reg(CFG_PLANE_Y, 21'(rand_comp()));
                    width = (n_phase == 9) ? 12'hFFF : 12'($urandom_range(3, 2048));
                end
            endcase
            set_reg(CFG_SCR_W, 21'(width));
            calm = (n_phase == 3);
            repeat (150) begin
                if ($urandom_range(99) < 35)
                    put_cell(5'($urandom), 5'($urandom),
                             $urandom_range(2) == 0 ? 4'd0 : 4'($urandom));
                else if ($urandom_range(9) == 0)
                    cast(11'($urandom));
                else
                    cast(11'($urandom_range(0, width > 2048 ? 2047 : width - 1)));
            end
            calm = 0;
        end

        drain();
        repeat (400) @(posedge clk);
        $display("Run covered %0d words (%0d ray casts, %0d map writes) over 13 camera setups;",
                 n_casts + n_writes, n_casts, n_writes);
        $display("%0d result words checked, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
